FILE: sv/a2b_pkg.sv
// Shared types, constants and palette helpers for the color code converter.
package a2b_pkg;

   localparam int unsigned CODE_W  = 8;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned RGB_W   = 24;
   localparam int unsigned DIST_W  = 29;
   localparam int unsigned NUM_BASE = 16;

   localparam logic [CODE_W-1:0] FG_LO     = 8'd30;
   localparam logic [CODE_W-1:0] FG_HI     = 8'd37;
   localparam logic [CODE_W-1:0] BRIGHT_LO = 8'd90;
   localparam logic [CODE_W-1:0] BRIGHT_HI = 8'd97;
   localparam logic [CODE_W-1:0] CUBE_BASE = 8'd16;
   localparam logic [CODE_W-1:0] GREY_BASE = 8'd232;

   localparam logic [RGB_W-1:0] BASE_RGB [NUM_BASE] = '{
      24'h000000, 24'hcd0000, 24'h00cd00, 24'hcdcd00,
      24'h0000ee, 24'hcd00cd, 24'h00cdcd, 24'he5e5e5,
      24'h7f7f7f, 24'hff0000, 24'h00ff00, 24'hffff00,
      24'h5c5cff, 24'hff00ff, 24'h00ffff, 24'hffffff
   };

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] tag;
      logic [RGB_W-1:0]   pix;
      logic [RGB_W-1:0]   cand;
   } dist_req_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] tag;
      logic [DIST_W-1:0]  distance;
   } dist_rsp_type;

   function automatic logic [7:0] cube_level(input logic [2:0] v);
      logic [7:0] lvl;
      if (v == 3'd0) begin
         lvl = 8'd0;
      end else begin
         lvl = 8'd55 + 8'd40 * {5'b0, v};
      end
      return lvl;
   endfunction

   function automatic logic [RGB_W-1:0] palette_rgb(input logic [CODE_W-1:0] idx);
      logic [7:0] c;
      logic [7:0] rem;
      logic [2:0] r;
      logic [2:0] g;
      logic [2:0] b;
      logic [7:0] v;
      logic [RGB_W-1:0] rgb;
      c   = 8'd0;
      rem = 8'd0;
      r   = 3'd0;
      g   = 3'd0;
      b   = 3'd0;
      v   = 8'd0;
      if (idx < CUBE_BASE) begin
         rgb = BASE_RGB[idx[INDEX_W-1:0]];
      end else if (idx < GREY_BASE) begin
         c = idx - CUBE_BASE;
         // digit-by-compare split of the cube offset into r, g, b
         r = (c >= 8'd180) ? 3'd5 : (c >= 8'd144) ? 3'd4 : (c >= 8'd108) ? 3'd3 :
             (c >= 8'd72)  ? 3'd2 : (c >= 8'd36)  ? 3'd1 : 3'd0;
         rem = c - 8'd36 * {5'b0, r};
         g = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
             (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6)  ? 3'd1 : 3'd0;
         b = 3'(rem - 8'd6 * {5'b0, g});
         rgb = {cube_level(r), cube_level(g), cube_level(b)};
      end else begin
         v = 8'd8 + 8'd10 * (idx - GREY_BASE);
         rgb = {v, v, v};
      end
      return rgb;
   endfunction

endpackage

FILE: sv/ansi256_to_base16_colour.sv
// Color code to base color index: sequencer, palette lookup and minimum search.
// SGR codes 30-37 and 90-97 are mapped directly in the check state; all other
// codes are palette codes (16 candidates through a 2-stage distance pipe).
// A new code is taken only once the last one is done; busy stays high until the result strobe.
// Reset is synchronous and clears only the sequencer, strobe and pipe valids;
// the receiver cannot stall, so each result is shown for exactly one cycle.
module ansi256_to_base16_colour (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [a2b_pkg::CODE_W-1:0]    req_colour_code,
   output logic                          rsp_valid,
   output logic [a2b_pkg::INDEX_W-1:0]   rsp_base_index
);
   import a2b_pkg::*;

   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [RGB_W-1:0]   rgb_ff, rgb_in;
   logic [INDEX_W-1:0] cnt_ff, cnt_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [INDEX_W-1:0] pick_ff, pick_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   dist_req_type dreq;
   dist_rsp_type drsp;
   logic         is_fg, is_bright, take;

   a2b_dist u_dist (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign is_fg     = code_ff inside {[FG_LO:FG_HI]};
   assign is_bright = code_ff inside {[BRIGHT_LO:BRIGHT_HI]};
   assign take      = drsp.valid && ((drsp.tag == '0) || (drsp.distance < best_ff));

   always_comb begin
      dreq.valid = (state_ff == ST_RUN);
      dreq.tag   = cnt_ff;
      dreq.pix   = rgb_ff;
      dreq.cand  = BASE_RGB[cnt_ff];
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rgb_in       = rgb_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      if (take) begin
         best_in = drsp.distance;
         pick_in = drsp.tag;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               code_in  = req_colour_code;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (is_fg) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_W'(code_ff - FG_LO);
               state_in     = ST_IDLE;
            end else if (is_bright) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_W'(code_ff - BRIGHT_LO) | 4'b1000;
               state_in     = ST_IDLE;
            end else begin
               rgb_in   = palette_rgb(code_ff);
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == INDEX_W'(NUM_BASE - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // last candidate leaves the pipe: fold its compare into the beat
            if (drsp.valid && (drsp.tag == INDEX_W'(NUM_BASE - 1))) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = take ? drsp.tag : pick_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      rgb_ff       <= rgb_in;
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_base_index = rsp_index_ff;

endmodule

FILE: sv/a2b_dist.sv
// Pipelined weighted red-mean distance unit, one candidate per cycle.
module a2b_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  a2b_pkg::dist_req_type req,
   output a2b_pkg::dist_rsp_type rsp
);
   import a2b_pkg::*;

   logic [7:0]  rx, ry, gx, gy, bx, by;
   logic [8:0]  rs;
   logic [7:0]  dr, dg, db;

   logic              s1_valid_ff, s1_valid_in;
   logic [INDEX_W-1:0] s1_tag_ff;
   logic [15:0]       s1_sqr_ff, s1_sqg_ff, s1_sqb_ff;
   logic [10:0]       s1_wr_ff, s1_wb_ff;

   logic              s2_valid_ff, s2_valid_in;
   logic [INDEX_W-1:0] s2_tag_ff;
   logic [26:0]       s2_pr_ff, s2_pg_ff, s2_pb_ff;

   always_comb begin
      rx = req.pix[23:16];
      gx = req.pix[15:8];
      bx = req.pix[7:0];
      ry = req.cand[23:16];
      gy = req.cand[15:8];
      by = req.cand[7:0];
      rs = {1'b0, rx} + {1'b0, ry};
      dr = (rx > ry) ? (rx - ry) : (ry - rx);
      dg = (gx > gy) ? (gx - gy) : (gy - gx);
      db = (bx > by) ? (bx - by) : (by - bx);
   end

   assign s1_valid_in = req.valid;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage 1: squares and red-mean weights
   always_ff @(posedge clock) begin
      s1_tag_ff <= req.tag;
      s1_sqr_ff <= {8'b0, dr} * {8'b0, dr};
      s1_sqg_ff <= {8'b0, dg} * {8'b0, dg};
      s1_sqb_ff <= {8'b0, db} * {8'b0, db};
      s1_wr_ff  <= 11'd1024 + {2'b0, rs};
      s1_wb_ff  <= 11'd1534 - {2'b0, rs};
   end

   // stage 2: weighted terms
   always_ff @(posedge clock) begin
      s2_tag_ff <= s1_tag_ff;
      s2_pr_ff  <= {16'b0, s1_wr_ff} * {11'b0, s1_sqr_ff};
      s2_pg_ff  <= {s1_sqg_ff, 11'b0};
      s2_pb_ff  <= {16'b0, s1_wb_ff} * {11'b0, s1_sqb_ff};
   end

   always_comb begin
      rsp.valid    = s2_valid_ff;
      rsp.tag      = s2_tag_ff;
      rsp.distance = {2'b0, s2_pr_ff} + {2'b0, s2_pg_ff} + {2'b0, s2_pb_ff};
   end

endmodule
